/* sv/drrt_pkg.sv */
// shared types and constants for the debounced retrigger relay timer
`default_nettype none
package drrt_pkg;

  localparam int NUM_LANES     = 3;
  localparam int LIMIT_W       = 8;
  localparam int COUNT_W       = 16;
  localparam int MS_W          = 10;
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 16;
  localparam int IN_DATA_W     = 8;
  localparam int IN_USER_W     = 1;
  localparam int OUT_DATA_W    = 8;

  localparam int MS_PER_SECOND = 1000;
  localparam int MS_HALF       = MS_PER_SECOND / 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET        = 8'd50;
  localparam logic [COUNT_W-1:0] LIGHT_RUNTIME_RESET = 16'd5;
  localparam logic [COUNT_W-1:0] DOOR_RUNTIME_RESET  = 16'd1;

  // lane order: light, door1, door2
  localparam int LANE_LIGHT = 0;
  localparam int LANE_DOOR1 = 1;
  localparam int LANE_DOOR2 = 2;

  // word kind on the input tuser bit
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE_LIMIT = 8'd0,
    REG_LIGHT_RUNTIME  = 8'd1,
    REG_DOOR1_RUNTIME  = 8'd2,
    REG_DOOR2_RUNTIME  = 8'd3
  } cfg_reg_t;

  // per-word control from the top into each lane
  typedef struct packed {
    logic sample;   // button sample accepted
    logic wrap;     // tick that completes a second
    logic reload;   // reload count from runtime after the button update
  } lane_ctrl_t;

  // what a lane reports back to the merge stage
  typedef struct packed {
    logic busy_pre; // count nonzero before any cross reload
    logic busy;     // count nonzero after this word
  } lane_stat_t;

endpackage
`default_nettype wire

/* sv/drrt_lane.sv */
// one button lane: counter debouncer and retriggerable run counter
`default_nettype none
module drrt_lane (
  input  wire                         clk,
  input  wire                         rst_n,
  input  drrt_pkg::lane_ctrl_t        ctrl,
  input  wire                         raw,
  input  wire [drrt_pkg::LIMIT_W-1:0] limit,
  input  wire [drrt_pkg::COUNT_W-1:0] runtime,
  output drrt_pkg::lane_stat_t        stat
);
  import drrt_pkg::*;

  logic               level_r, level_nxt;
  logic [LIMIT_W-1:0] dbc_r, dbc_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [LIMIT_W-1:0] dbc_inc;
  logic [COUNT_W-1:0] cnt_pre;

  assign dbc_inc = dbc_r + LIMIT_W'(1);

  always_comb begin
    level_nxt = level_r;
    dbc_nxt   = dbc_r;
    cnt_pre   = cnt_r;
    if (ctrl.sample) begin
      if (level_r != raw) begin
        if (dbc_inc >= limit) begin
          dbc_nxt   = '0;
          level_nxt = raw;
        end else begin
          dbc_nxt = dbc_inc;
        end
      end else begin
        dbc_nxt = '0;
      end
      // pressed button holds the count at its runtime
      if (!level_nxt) begin
        cnt_pre = runtime;
      end
    end else if (ctrl.wrap) begin
      if (cnt_r != '0) begin
        cnt_pre = cnt_r - COUNT_W'(1);
      end
    end
    cnt_nxt       = ctrl.reload ? runtime : cnt_pre;
    stat.busy_pre = (cnt_pre != '0);
    stat.busy     = (cnt_nxt != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= 1'b1;
      dbc_r   <= '0;
      cnt_r   <= '0;
    end else begin
      level_r <= level_nxt;
      dbc_r   <= dbc_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/debounced_retrigger_relay_timer.sv */
// top level: config registers, ms timer, three button lanes, merge and output buffer
// a result goes to the output register, or to the skid register while that one waits;
//   one input word per cycle unless the skid is full; lanes and ms counter update in the
//   accepting cycle, and the skid keeps in_tready high while one result waits
// reset (rst_n low, synchronous): config registers to their defaults, counters and
//   blink/raw LEDs cleared, debounced levels released, output buffer empty
`default_nettype none
module debounced_retrigger_relay_timer (
  input  wire                            clk,
  input  wire                            rst_n,
  // input stream
  input  wire                            in_tvalid,
  output logic                           in_tready,
  input  wire [drrt_pkg::IN_DATA_W-1:0]  in_tdata,   // [2:0] buttons, rest zero
  input  wire [drrt_pkg::IN_USER_W-1:0]  in_tuser,   // [0] op: 0 sample, 1 ms tick
  // result stream
  output logic                           out_tvalid,
  input  wire                            out_tready,
  output logic [drrt_pkg::OUT_DATA_W-1:0] out_tdata, // [0] light drive, [1] door1 drive,
                                                     // [2] door2 drive, [3] blink_led,
                                                     // [4] raw_led, rest zero
  // config write channel
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire [drrt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [drrt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import drrt_pkg::*;

  // config registers
  logic [LIMIT_W-1:0] limit_r;
  logic [COUNT_W-1:0] rt_r [NUM_LANES];

  // timer and LED state
  logic [MS_W-1:0] ms_r, ms_nxt;
  logic            blink_r, blink_nxt;
  logic            raw_led_r, raw_led_nxt;

  // output buffer
  logic                  out_vld_r, out_vld_nxt;
  logic [OUT_DATA_W-1:0] out_dat_r, out_dat_nxt;
  logic                  skd_vld_r, skd_vld_nxt;
  logic [OUT_DATA_W-1:0] skd_dat_r, skd_dat_nxt;

  logic            in_acc, out_take;
  logic            is_tick, is_sample;
  logic [MS_W-1:0] ms_inc;
  logic            at_half, at_wrap;
  logic [2:0]      buttons;
  logic [OUT_DATA_W-1:0] result;

  lane_ctrl_t ctrl [NUM_LANES];
  lane_stat_t stat [NUM_LANES];

  assign cfg_ready = 1'b1;

  // config writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r           <= LIMIT_RESET;
      rt_r[LANE_LIGHT]  <= LIGHT_RUNTIME_RESET;
      rt_r[LANE_DOOR1]  <= DOOR_RUNTIME_RESET;
      rt_r[LANE_DOOR2]  <= DOOR_RUNTIME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DEBOUNCE_LIMIT: limit_r          <= cfg_data[LIMIT_W-1:0];
        REG_LIGHT_RUNTIME:  rt_r[LANE_LIGHT] <= cfg_data;
        REG_DOOR1_RUNTIME:  rt_r[LANE_DOOR1] <= cfg_data;
        REG_DOOR2_RUNTIME:  rt_r[LANE_DOOR2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_acc    = in_tvalid && in_tready;
  assign out_take  = out_tvalid && out_tready;
  assign is_tick   = in_acc && (in_tuser[0] == OP_TICK);
  assign is_sample = in_acc && (in_tuser[0] == OP_SAMPLE);
  assign buttons   = in_tdata[2:0];

  // millisecond counter: blink toggles at the half and at the full second,
  // the full second also wraps the counter and ages every run count
  assign ms_inc  = ms_r + MS_W'(1);
  assign at_half = (ms_inc == MS_W'(MS_HALF));
  assign at_wrap = (ms_inc == MS_W'(MS_PER_SECOND));

  always_comb begin
    ms_nxt      = ms_r;
    blink_nxt   = blink_r;
    raw_led_nxt = raw_led_r;
    if (is_tick) begin
      ms_nxt = at_wrap ? '0 : ms_inc;
      if (at_half || at_wrap) begin
        blink_nxt = ~blink_r;
      end
    end
    if (is_sample) begin
      // led mirrors the last button looked at, active low
      raw_led_nxt = ~buttons[LANE_DOOR2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_r      <= '0;
      blink_r   <= 1'b0;
      raw_led_r <= 1'b0;
    end else begin
      ms_r      <= ms_nxt;
      blink_r   <= blink_nxt;
      raw_led_r <= raw_led_nxt;
    end
  end

  // lanes; a running door count retriggers the light count after the
  // light lane has done its own button update
  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      ctrl[k].sample = is_sample;
      ctrl[k].wrap   = is_tick && at_wrap;
      ctrl[k].reload = 1'b0;
    end
    ctrl[LANE_LIGHT].reload = is_sample &&
                              (stat[LANE_DOOR1].busy_pre || stat[LANE_DOOR2].busy_pre);
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    drrt_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl[g]),
      .raw     (buttons[g]),
      .limit   (limit_r),
      .runtime (rt_r[g]),
      .stat    (stat[g])
    );
  end

  // merge: light relay is judged before the door retrigger
  always_comb begin
    result    = '0;
    result[0] = stat[LANE_LIGHT].busy_pre;
    result[1] = stat[LANE_DOOR1].busy;
    result[2] = stat[LANE_DOOR2].busy;
    result[3] = blink_nxt;
    result[4] = raw_led_nxt;
  end

  // output register with skid stage; input stalls only when both are full
  assign in_tready  = !skd_vld_r;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_dat_r;

  always_comb begin
    out_vld_nxt = out_vld_r;
    out_dat_nxt = out_dat_r;
    skd_vld_nxt = skd_vld_r;
    skd_dat_nxt = skd_dat_r;
    if (skd_vld_r) begin
      if (out_take) begin
        out_dat_nxt = skd_dat_r;
        skd_vld_nxt = 1'b0;
      end
    end else if (in_acc) begin
      if (!out_vld_r || out_take) begin
        out_vld_nxt = 1'b1;
        out_dat_nxt = result;
      end else begin
        skd_vld_nxt = 1'b1;
        skd_dat_nxt = result;
      end
    end else if (out_take) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      skd_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      skd_vld_r <= skd_vld_nxt;
    end
    out_dat_r <= out_dat_nxt;
    skd_dat_r <= skd_dat_nxt;
  end

endmodule
`default_nettype wire
